>>> design/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// shared types, constants and helper functions for the euler angle unit
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int GUARD_BITS = 8;
  localparam int DW         = 28;  // cordic datapath width
  localparam int ZW         = 21;  // angle accumulator width, q.16 radians
  localparam int AW         = 16;  // output angle width, q3.13

  localparam logic signed [ZW-1:0] PI_Q16      = 21'sd205887;
  localparam logic signed [AW-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [AW-1:0] ANGLE_MAX   = 16'sd25736;
  localparam logic [14:0]          KINV_Q15    = 15'd19898;
  localparam logic [1:0]           LOCK_NONE   = 2'd0;
  localparam logic [1:0]           LOCK_POS    = 2'd1;
  localparam logic [1:0]           LOCK_NEG    = 2'd2;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_beat_t;

  typedef struct packed {
    logic signed [AW-1:0] roll_angle;
    logic signed [AW-1:0] pitch_angle;
    logic signed [AW-1:0] yaw_angle;
    logic [1:0]           lock_case;
  } out_beat_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  function automatic logic [16:0] atan_entry(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30386;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round q.16 to q3.13 and saturate
  function automatic logic signed [AW-1:0] to_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    logic signed [ZW:0] r;
    logic signed [AW-1:0] o;
    t = {z[ZW-1], z} + 22'sd4;
    r = t >>> 3;
    if (r > 22'(ANGLE_MAX)) begin
      o = ANGLE_MAX;
    end else if (r < -22'(ANGLE_MAX)) begin
      o = -ANGLE_MAX;
    end else begin
      o = r[AW-1:0];
    end
    return o;
  endfunction

endpackage

>>> design/rotation_matrix_to_euler_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_unit
// rotation matrix to z-y-x euler angles with gimbal lock detection
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall/in_data carries seven q2.14 matrix entries
//   per beat; output channel out_valid/out_stall/out_data returns roll, pitch,
//   yaw (q3.13 radians) and the lock case, one result beat per input beat.
//   cfg_we/cfg_wdata write the gimbal lock tolerance (reset value 8); write it
//   only while the unit is empty.
//   the pipeline holds a fold stage and one stage per rotation in each of two
//   cordic pipelines, the magnitude scaling stage and the output register.
//   throughput is one beat per cycle while the output is not stalled. the
//   three first-level cordics run in parallel; pitch needs the magnitude and
//   so runs in a second pipeline. out_stall freezes the whole pipeline while
//   a result is held in the output register, and in_stall rises only then.
//   no beat is lost.
//   reset (rst_n low, synchronous) empties the pipeline and restores the
//   tolerance.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rme_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rme_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import rme_pkg::*;

  localparam int SIDE2 = 3 * ZW;

  logic                 en;
  logic [7:0]           tol_r;
  logic                 out_valid_r;
  out_beat_t            out_r, out_nxt;

  logic signed [DW-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic                 a_v, b_v, c_v;
  logic signed [ZW-1:0] a_z, b_z, c_z;
  logic signed [DW-1:0] a_mag, b_mag, c_mag;
  logic [15:0]          a_side;
  logic                 b_side, c_side;

  logic                 h_v_r;
  logic signed [DW-1:0] hyp_r, hyp_nxt;
  logic signed [43:0]   prod;
  logic signed [15:0]   m20_r;
  logic [SIDE2-1:0]     ang_r;

  logic signed [DW-1:0] p_y;
  logic                 p_v;
  logic signed [ZW-1:0] p_z;
  logic signed [DW-1:0] p_mag;
  logic [SIDE2-1:0]     p_side;

  logic signed [AW-1:0] pitch, yaw_n, roll_n, roll_l;
  logic signed [AW+1:0] d_pos, d_neg;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 8'd8;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign a_x = DW'(in_data.m00) <<< GUARD_BITS;
  assign a_y = DW'(in_data.m10) <<< GUARD_BITS;
  assign b_x = DW'(in_data.m22) <<< GUARD_BITS;
  assign b_y = DW'(in_data.m21) <<< GUARD_BITS;
  assign c_x = DW'(in_data.m11) <<< GUARD_BITS;
  assign c_y = DW'(in_data.m01) <<< GUARD_BITS;

  // yaw and magnitude
  rme_cordic #(.STAGES(CORDIC_STAGES), .SW(16)) u_cordic_yaw (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(in_valid),
    .x_i(a_x), .y_i(a_y), .side_i(in_data.m20),
    .valid_o(a_v), .z_o(a_z), .mag_o(a_mag), .side_o(a_side)
  );

  // roll, normal case
  rme_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_cordic_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(in_valid),
    .x_i(b_x), .y_i(b_y), .side_i(1'b0),
    .valid_o(b_v), .z_o(b_z), .mag_o(b_mag), .side_o(b_side)
  );

  // roll, locked case
  rme_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_cordic_lock (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(in_valid),
    .x_i(c_x), .y_i(c_y), .side_i(1'b0),
    .valid_o(c_v), .z_o(c_z), .mag_o(c_mag), .side_o(c_side)
  );

  // gain compensation of the magnitude
  assign prod    = 44'(a_mag) * $signed({1'b0, KINV_Q15}) + 44'sd16384;
  assign hyp_nxt = DW'(prod >>> 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hyp_r <= hyp_nxt;
      m20_r <= a_side;
      ang_r <= {a_z, b_z, c_z};
    end
  end

  assign p_y = -(DW'(m20_r) <<< GUARD_BITS);

  rme_cordic #(.STAGES(CORDIC_STAGES), .SW(SIDE2)) u_cordic_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(h_v_r),
    .x_i(hyp_r), .y_i(p_y), .side_i(ang_r),
    .valid_o(p_v), .z_o(p_z), .mag_o(p_mag), .side_o(p_side)
  );

  always_comb begin
    pitch  = to_q13(p_z);
    yaw_n  = to_q13(p_side[3*ZW-1:2*ZW]);
    roll_n = to_q13(p_side[2*ZW-1:ZW]);
    roll_l = to_q13(p_side[ZW-1:0]);
    d_pos  = 18'(pitch) - 18'(HALF_PI_Q13);
    d_neg  = 18'(pitch) + 18'(HALF_PI_Q13);
    if (d_pos[AW+1]) d_pos = -d_pos;
    if (d_neg[AW+1]) d_neg = -d_neg;
    out_nxt.pitch_angle = pitch;
    if (d_pos < $signed({10'd0, tol_r})) begin
      out_nxt.lock_case  = LOCK_POS;
      out_nxt.yaw_angle  = '0;
      out_nxt.roll_angle = roll_l;
    end else if (d_neg < $signed({10'd0, tol_r})) begin
      out_nxt.lock_case  = LOCK_NEG;
      out_nxt.yaw_angle  = '0;
      out_nxt.roll_angle = -roll_l;
    end else begin
      out_nxt.lock_case  = LOCK_NONE;
      out_nxt.yaw_angle  = yaw_n;
      out_nxt.roll_angle = roll_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_lock_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.lock_case != 2'd3))
    else $error("invalid lock case");

  a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.lock_case != LOCK_NONE) |-> (out_r.yaw_angle == '0))
    else $error("yaw not cleared in lock");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.pitch_angle <= ANGLE_MAX && out_r.pitch_angle >= -ANGLE_MAX))
    else $error("pitch out of range");

  a_lock_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.lock_case == LOCK_POS) |-> !out_r.pitch_angle[AW-1])
    else $error("positive lock with negative pitch");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && !$past(!rst_n)) |=> (out_valid_r && $stable(h_v_r)))
    else $error("pipeline moved while frozen");

endmodule

>>> design/rme_cordic_stage.sv
// ----------------------------------------------------------------------------
// rme_cordic_stage
// one registered vectoring micro-rotation
// ----------------------------------------------------------------------------
module rme_cordic_stage #(
  parameter int IDX = 0,
  parameter int SW  = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  rme_pkg::ctl_t                 ctl_i,
  input  logic signed [rme_pkg::DW-1:0] x_i,
  input  logic signed [rme_pkg::DW-1:0] y_i,
  input  logic signed [rme_pkg::ZW-1:0] z_i,
  input  logic [SW-1:0]                 side_i,
  output rme_pkg::ctl_t                 ctl_o,
  output logic signed [rme_pkg::DW-1:0] x_o,
  output logic signed [rme_pkg::DW-1:0] y_o,
  output logic signed [rme_pkg::ZW-1:0] z_o,
  output logic [SW-1:0]                 side_o
);
  import rme_pkg::*;

  localparam logic [4:0] TI = 5'(IDX);

  logic signed [DW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt, tab;
  ctl_t                 ctl_r;
  logic signed [DW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [SW-1:0]        side_r;

  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    tab = ZW'(atan_entry(TI));
    if (!y_i[DW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + tab;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - tab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

>>> design/rme_cordic.sv
// ----------------------------------------------------------------------------
// rme_cordic
// pipelined vectoring cordic: quadrant fold stage then one stage per rotation
// ----------------------------------------------------------------------------
module rme_cordic #(
  parameter int STAGES = 16,
  parameter int SW     = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic signed [rme_pkg::DW-1:0] x_i,
  input  logic signed [rme_pkg::DW-1:0] y_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic signed [rme_pkg::ZW-1:0] z_o,
  output logic signed [rme_pkg::DW-1:0] mag_o,
  output logic [SW-1:0]                 side_o
);
  import rme_pkg::*;

  ctl_t                 ctl_w [0:STAGES];
  logic signed [DW-1:0] x_w   [0:STAGES];
  logic signed [DW-1:0] y_w   [0:STAGES];
  logic signed [ZW-1:0] z_w   [0:STAGES];
  logic [SW-1:0]        sd_w  [0:STAGES];

  ctl_t                 ctl_r;
  logic signed [DW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [SW-1:0]        side_r;

  // fold left half plane into the right
  always_comb begin
    if (x_i[DW-1]) begin
      x_nxt = -x_i;
      y_nxt = -y_i;
      z_nxt = y_i[DW-1] ? -PI_Q16 : PI_Q16;
    end else begin
      x_nxt = x_i;
      y_nxt = y_i;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r.valid <= valid_i;
      ctl_r.zero  <= (x_i == '0) && (y_i == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign ctl_w[0] = ctl_r;
  assign x_w[0]   = x_r;
  assign y_w[0]   = y_r;
  assign z_w[0]   = z_r;
  assign sd_w[0]  = side_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    rme_cordic_stage #(.IDX(i), .SW(SW)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_w[i]),
      .x_i    (x_w[i]),
      .y_i    (y_w[i]),
      .z_i    (z_w[i]),
      .side_i (sd_w[i]),
      .ctl_o  (ctl_w[i+1]),
      .x_o    (x_w[i+1]),
      .y_o    (y_w[i+1]),
      .z_o    (z_w[i+1]),
      .side_o (sd_w[i+1])
    );
  end

  assign valid_o = ctl_w[STAGES].valid;
  assign z_o     = ctl_w[STAGES].zero ? '0 : z_w[STAGES];
  assign mag_o   = ctl_w[STAGES].zero ? '0 : x_w[STAGES];
  assign side_o  = sd_w[STAGES];

endmodule
